// File: hdl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 3;
   localparam int DIM_W       = 4;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // command codes on req_cmd
   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      OP_LOAD_A,
      OP_LOAD_B,
      OP_COMPUTE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      logic [DATA_W-1:0]   value;
   } q_entry_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } bk_state_type;

   // tag that travels with one multiply-accumulate step
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             final_res;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mac_tag_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows_a;
      logic [DIM_W-1:0] inner_dim;
      logic [DIM_W-1:0] cols_b;
   } dims_type;

endpackage

// File: hdl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Integer matrix product engine with stored A and B matrices.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: a transfer happens on a clock edge with start high and
//    busy low. req_cmd selects load A, load B or compute; loads write
//    req_elem_value at (req_elem_row, req_elem_col). Unused codes and loads
//    outside the stores are dropped.
//  - Loads transfer one per cycle while busy is low; a short queue buffers
//    requests while the engine runs, and busy rises only when that queue
//    and the decode stage are full.
//  - A compute runs one multiply-accumulate per cycle through the single
//    multiplier and returns rows_a*cols_b results in row-major order. The
//    compute request passes the decode stage and the queue; its products then
//    pass the store read, the multiply and the accumulate and output register.
//  - Results: rsp_valid strobes for one cycle per result; rsp_last_result
//    marks the final element. The receiver cannot stall.
//  - Configuration: csr_write_enable writes csr_write_data into the register
//    at csr_index (rows_a, inner_dim, cols_b); write only when idle.
//    Dimensions are clamped into 1..min(MAX_DIM,8) at compute start.
//  - Reset (synchronous) empties the queue and pipeline and sets all three
//    dimensions to 8. Stored matrix entries are undefined until loaded.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [imm_pkg::CMD_W-1:0]           req_cmd,
   input  logic [imm_pkg::IDX_W-1:0]           req_elem_row,
   input  logic [imm_pkg::IDX_W-1:0]           req_elem_col,
   input  logic signed [imm_pkg::DATA_W-1:0]   req_elem_value,
   output logic                                rsp_valid,
   output logic [imm_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0]   rsp_product_value,
   output logic                                rsp_last_result,
   input  logic                                csr_write_enable,
   input  logic [imm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [imm_pkg::DIM_W-1:0]           csr_write_data
);

   imm_pkg::dims_type    dims_ff, dims_in;
   logic                 push;
   imm_pkg::q_entry_type push_entry;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 pop;
   imm_pkg::q_entry_type pop_entry;

   // configuration registers; an index past the list is ignored
   always_comb begin
      dims_in = dims_ff;
      if (csr_write_enable) begin
         case (csr_index)
            imm_pkg::CSR_ROWS_A:    dims_in.rows_a    = csr_write_data;
            imm_pkg::CSR_INNER_DIM: dims_in.inner_dim = csr_write_data;
            imm_pkg::CSR_COLS_B:    dims_in.cols_b    = csr_write_data;
            default:                dims_in           = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.rows_a    <= imm_pkg::DIM_RESET;
         dims_ff.inner_dim <= imm_pkg::DIM_RESET;
         dims_ff.cols_b    <= imm_pkg::DIM_RESET;
      end else begin
         dims_ff <= dims_in;
      end
   end

   // front end: request transfer and decode
   imm_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_elem_row   (req_elem_row),
      .req_elem_col   (req_elem_col),
      .req_elem_value (req_elem_value),
      .push           (push),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   // decoupling queue
   imm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   // back end: stores and multiply-accumulate
   imm_engine #(
      .MAX_DIM (MAX_DIM)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .dims              (dims_ff),
      .queue_empty       (queue_empty),
      .queue_entry       (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

// File: hdl/imm_front.sv
// ----------------------------------------------------------------------------
// imm_front
// Request front end: takes requests, decodes them and pushes them to the queue.
// ----------------------------------------------------------------------------
module imm_front #(
   parameter int MAX_DIM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [imm_pkg::CMD_W-1:0]           req_cmd,
   input  logic [imm_pkg::IDX_W-1:0]           req_elem_row,
   input  logic [imm_pkg::IDX_W-1:0]           req_elem_col,
   input  logic signed [imm_pkg::DATA_W-1:0]   req_elem_value,
   output logic                                push,
   output imm_pkg::q_entry_type                push_entry,
   input  logic                                queue_full
);

   logic                 stage_valid_ff, stage_valid_in;
   imm_pkg::q_entry_type stage_ff, stage_in;
   logic                 accept;
   logic                 keep;
   logic                 in_range;

   assign busy   = stage_valid_ff && queue_full;
   assign accept = start && !busy;
   assign push   = stage_valid_ff && !queue_full;
   assign push_entry = stage_ff;

   assign in_range = (int'(req_elem_row) < MAX_DIM) && (int'(req_elem_col) < MAX_DIM);

   // decode: unused codes and out-of-range loads are dropped here
   always_comb begin
      stage_in.row   = req_elem_row;
      stage_in.col   = req_elem_col;
      stage_in.value = $unsigned(req_elem_value);
      stage_in.op    = imm_pkg::OP_COMPUTE;
      keep           = 1'b0;
      case (req_cmd)
         imm_pkg::CMD_LOAD_A: begin
            stage_in.op = imm_pkg::OP_LOAD_A;
            keep        = in_range;
         end
         imm_pkg::CMD_LOAD_B: begin
            stage_in.op = imm_pkg::OP_LOAD_B;
            keep        = in_range;
         end
         imm_pkg::CMD_COMPUTE: begin
            stage_in.op = imm_pkg::OP_COMPUTE;
            keep        = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = keep;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: hdl/imm_queue.sv
// ----------------------------------------------------------------------------
// imm_queue
// Small FIFO of decoded requests between the front end and the engine.
// ----------------------------------------------------------------------------
module imm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  imm_pkg::q_entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output imm_pkg::q_entry_type pop_entry,
   output logic                 empty
);

   imm_pkg::q_entry_type             slot_ff [imm_pkg::QUEUE_DEPTH];
   logic [imm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [imm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [imm_pkg::QPTR_W:0]         count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == (imm_pkg::QPTR_W+1)'(imm_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/imm_engine.sv
// ----------------------------------------------------------------------------
// imm_engine
// Matrix stores and the multiply-accumulate engine that forms the product.
// ----------------------------------------------------------------------------
module imm_engine #(
   parameter int MAX_DIM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  imm_pkg::dims_type                   dims,
   input  logic                                queue_empty,
   input  imm_pkg::q_entry_type                queue_entry,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic [imm_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0]   rsp_product_value,
   output logic                                rsp_last_result
);

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [imm_pkg::IDX_W-1:0] r,
                                                  input logic [imm_pkg::IDX_W-1:0] c);
      logic [ADDR_W+imm_pkg::IDX_W-1:0] full_addr;
      full_addr = (ADDR_W+imm_pkg::IDX_W)'(r) * (ADDR_W+imm_pkg::IDX_W)'(MAX_DIM)
                + (ADDR_W+imm_pkg::IDX_W)'(c);
      return full_addr[ADDR_W-1:0];
   endfunction

   function automatic logic [imm_pkg::DIM_W-1:0] clamp_dim(
         input logic [imm_pkg::DIM_W-1:0] v);
      logic [imm_pkg::DIM_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = imm_pkg::DIM_W'(1);
      end else if (v > imm_pkg::DIM_W'(DIM_CAP)) begin
         res = imm_pkg::DIM_W'(DIM_CAP);
      end
      return res;
   endfunction

   logic [imm_pkg::DATA_W-1:0] mem_a [DEPTH];
   logic [imm_pkg::DATA_W-1:0] mem_b [DEPTH];

   imm_pkg::bk_state_type      state_ff, state_in;
   logic [imm_pkg::IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [imm_pkg::DIM_W-1:0]  rn_ff, rn_in, kn_ff, kn_in, cn_ff, cn_in;
   logic                       i_last, j_last, k_last;
   logic                       issue;
   logic                       wr_a, wr_b;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ADDR_W-1:0]          rd_addr_a, rd_addr_b;

   imm_pkg::mac_tag_type       tag_issue;
   imm_pkg::mac_tag_type       tag1_ff, tag2_ff;
   logic [imm_pkg::DATA_W-1:0] a_rd_ff, b_rd_ff;
   logic [imm_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [imm_pkg::DATA_W-1:0] acc_ff, acc_in;

   logic                       rsp_valid_ff;
   logic [imm_pkg::IDX_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic [imm_pkg::DATA_W-1:0] rsp_value_ff;
   logic                       rsp_last_ff;

   assign i_last = ({1'b0, i_ff} + 1'b1) == rn_ff;
   assign j_last = ({1'b0, j_ff} + 1'b1) == cn_ff;
   assign k_last = ({1'b0, k_ff} + 1'b1) == kn_ff;

   assign wr_addr   = addr_of(queue_entry.row, queue_entry.col);
   assign rd_addr_a = addr_of(i_ff, k_ff);
   assign rd_addr_b = addr_of(k_ff, j_ff);

   // sequencer: a load is written straight from idle, a product walks i, j, k
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      wr_a     = 1'b0;
      wr_b     = 1'b0;
      issue    = 1'b0;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      rn_in    = rn_ff;
      kn_in    = kn_ff;
      cn_in    = cn_ff;
      case (state_ff)
         imm_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               case (queue_entry.op)
                  imm_pkg::OP_LOAD_A: wr_a = 1'b1;
                  imm_pkg::OP_LOAD_B: wr_b = 1'b1;
                  imm_pkg::OP_COMPUTE: begin
                     rn_in    = clamp_dim(dims.rows_a);
                     kn_in    = clamp_dim(dims.inner_dim);
                     cn_in    = clamp_dim(dims.cols_b);
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = imm_pkg::BK_RUN;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         imm_pkg::BK_RUN: begin
            issue = 1'b1;
            if (!k_last) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (!j_last) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if (!i_last) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     state_in = imm_pkg::BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = imm_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      tag_issue.valid     = issue;
      tag_issue.first     = (k_ff == '0);
      tag_issue.last_k    = k_last;
      tag_issue.final_res = k_last && j_last && i_last;
      tag_issue.row       = i_ff;
      tag_issue.col       = j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      rn_ff <= rn_in;
      kn_ff <= kn_in;
      cn_ff <= cn_in;
   end

   // matrix stores: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= queue_entry.value;
      end
      a_rd_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[wr_addr] <= queue_entry.value;
      end
      b_rd_ff <= mem_b[rd_addr_b];
   end

   // low 32 bits of the product are all the wrapped sum needs
   assign prod_in = a_rd_ff * b_rd_ff;
   assign acc_in  = tag2_ff.first ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= tag_issue;
         tag2_ff      <= tag1_ff;
         rsp_valid_ff <= tag2_ff.valid && tag2_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag2_ff.valid) begin
         acc_ff       <= acc_in;
         rsp_row_ff   <= tag2_ff.row;
         rsp_col_ff   <= tag2_ff.col;
         rsp_value_ff <= acc_in;
         rsp_last_ff  <= tag2_ff.final_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = $signed(rsp_value_ff);
   assign rsp_last_result   = rsp_last_ff;

endmodule
